// File: design/plst_pkg.sv
// Shared types, widths and codes for the positional list store.
package plst_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 5;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DATA_W = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [CMP_W-1:0] cmp_type;
   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_SEARCH    = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic     ins;
      logic     del;
      idx_type  idx;
      data_type value;
   } cell_ctl_type;

   typedef struct packed {
      status_type status;
      data_type   removed_value;
      pos_type    found_position;
      pos_type    length;
   } rsp_type;

endpackage

// File: design/plst_if.sv
// Request and response channel interfaces of the positional list store.
interface plst_req_if;
   logic                 valid;
   logic                 ready;
   logic [2:0]           command;
   plst_pkg::data_type   value;
   plst_pkg::pos_type    position;

   modport source(output valid, command, value, position, input ready);
   modport sink(input valid, command, value, position, output ready);
endinterface

interface plst_rsp_if;
   logic                   valid;
   logic                   ready;
   plst_pkg::status_type   status;
   plst_pkg::data_type     removed_value;
   plst_pkg::pos_type      found_position;
   plst_pkg::pos_type      length;

   modport source(output valid, status, removed_value, found_position, length, input ready);
   modport sink(input valid, status, removed_value, found_position, length, output ready);
endinterface

// File: design/positional_list_store_core.sv
// Top level of the positional list store: a chain of entry cells and its controller.
//
//   channel   direction   handshake          carries
//   req_chan  in          valid / ready      command, value, position
//   rsp_chan  out         valid / ready      status, removed_value, found_position, length
//
// Every cell shifts or compares at once, and the result is registered at the
// edge that accepts the request.
// A new request is taken whenever the response register is empty or is being drained.
// Reset clears the length and the response valid flag; cell contents are not reset.
// A stalled response holds the request channel off until it is taken.
module positional_list_store_core (
   input  logic        clock,
   input  logic        reset,
   plst_req_if.sink    req_chan,
   plst_rsp_if.source  rsp_chan
);

   plst_pkg::cell_ctl_type       ctl;
   plst_pkg::cnt_type            count;
   plst_pkg::data_type           entry_w [plst_pkg::DEPTH];
   plst_pkg::data_type           pick_w  [plst_pkg::DEPTH];
   logic [plst_pkg::DEPTH-1:0]   match_w;
   plst_pkg::data_type           pick_data;
   plst_pkg::rsp_type            rsp;
   logic                         accept;
   logic                         req_ready;
   logic                         rsp_valid;

   assign accept = req_chan.valid && req_ready;

   for (genvar i = 0; i < plst_pkg::DEPTH; i++) begin : g_cell
      plst_pkg::data_type left_value;
      plst_pkg::data_type right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = entry_w[i-1];
      end
      if (i == plst_pkg::DEPTH - 1) begin : g_last
         assign right_value = entry_w[i];
      end else begin : g_inner_right
         assign right_value = entry_w[i+1];
      end

      plst_cell u_cell (
         .clock       (clock),
         .cell_index  (plst_pkg::idx_type'(i)),
         .ctl         (ctl),
         .count       (count),
         .left_value  (left_value),
         .right_value (right_value),
         .entry       (entry_w[i]),
         .match       (match_w[i]),
         .pick        (pick_w[i])
      );
   end

   always_comb begin
      pick_data = '0;
      for (int i = 0; i < plst_pkg::DEPTH; i++) begin
         pick_data = pick_data | pick_w[i];
      end
   end

   plst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_chan.command),
      .value     (req_chan.value),
      .position  (req_chan.position),
      .rsp_ready (rsp_chan.ready),
      .match     (match_w),
      .pick_data (pick_data),
      .ctl       (ctl),
      .count     (count),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.status         = rsp.status;
   assign rsp_chan.removed_value  = rsp.removed_value;
   assign rsp_chan.found_position = rsp.found_position;
   assign rsp_chan.length         = rsp.length;

   // The list never grows past its capacity.
   assert property (@(posedge clock) disable iff (reset)
      count <= plst_pkg::cnt_type'(plst_pkg::DEPTH))
      else $error("list length exceeds capacity");

   // Every accepted transaction leaves a response waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted transaction produced no response");

   // A delete on an empty list reports empty and leaves the length at zero.
   assert property (@(posedge clock) disable iff (reset)
      accept && count == '0 &&
      (req_chan.command == plst_pkg::CMD_DEL_FRONT ||
       req_chan.command == plst_pkg::CMD_DEL_BACK ||
       req_chan.command == plst_pkg::CMD_DEL_AT)
      |=> rsp_chan.status == plst_pkg::ST_EMPTY && count == '0)
      else $error("delete on empty list misreported");

   // A successful delete shortens the list by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      ctl.del |=> count == $past(count) - 1'b1)
      else $error("delete did not shorten the list");

endmodule

// File: design/plst_cell.sv
// One list cell: holds an entry, shifts toward either neighbor and compares.
module plst_cell (
   input  logic                   clock,
   input  plst_pkg::idx_type      cell_index,
   input  plst_pkg::cell_ctl_type ctl,
   input  plst_pkg::cnt_type      count,
   input  plst_pkg::data_type     left_value,
   input  plst_pkg::data_type     right_value,
   output plst_pkg::data_type     entry,
   output logic                   match,
   output plst_pkg::data_type     pick
);

   plst_pkg::data_type entry_ff;
   plst_pkg::data_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (cell_index > ctl.idx) begin
            entry_in = left_value;
         end else if (cell_index == ctl.idx) begin
            entry_in = ctl.value;
         end
      end else if (ctl.del) begin
         if (cell_index >= ctl.idx) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // Only cells that lie inside the list may report a match.
   assign match = (entry_ff == ctl.value) &&
                  (plst_pkg::cnt_type'(cell_index) < count);
   assign pick  = (cell_index == ctl.idx) ? entry_ff : '0;

endmodule

// File: design/plst_ctrl.sv
// Command decode, length counter and response register of the list store.
module plst_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [2:0]                command,
   input  plst_pkg::data_type        value,
   input  plst_pkg::pos_type         position,
   input  logic                      rsp_ready,
   input  logic [plst_pkg::DEPTH-1:0] match,
   input  plst_pkg::data_type        pick_data,
   output plst_pkg::cell_ctl_type    ctl,
   output plst_pkg::cnt_type         count,
   output logic                      req_ready,
   output logic                      rsp_valid,
   output plst_pkg::rsp_type         rsp
);

   plst_pkg::cnt_type    count_ff;
   plst_pkg::cnt_type    count_in;
   logic                 rsp_valid_ff;
   plst_pkg::rsp_type    rsp_ff;
   plst_pkg::rsp_type    rsp_in;
   plst_pkg::status_type status;
   plst_pkg::cnt_type    first_pos;
   logic                 do_ins;
   logic                 do_del;
   logic                 full;
   logic                 empty;
   plst_pkg::idx_type    idx;

   assign full  = (count_ff == plst_pkg::cnt_type'(plst_pkg::DEPTH));
   assign empty = (count_ff == '0);

   // Lowest matching cell wins.
   always_comb begin
      first_pos = '0;
      for (int i = plst_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            first_pos = plst_pkg::cnt_type'(i + 1);
         end
      end
   end

   always_comb begin
      status = plst_pkg::ST_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      idx    = '0;
      unique case (plst_pkg::cmd_type'(command))
         plst_pkg::CMD_INS_FRONT: begin
            if (full) status = plst_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         plst_pkg::CMD_INS_BACK: begin
            idx = plst_pkg::idx_type'(count_ff);
            if (full) status = plst_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         plst_pkg::CMD_INS_AT: begin
            idx = plst_pkg::idx_type'(position);
            if (full) begin
               status = plst_pkg::ST_FULL;
            end else if (plst_pkg::cmp_type'(position) > plst_pkg::cmp_type'(count_ff)) begin
               status = plst_pkg::ST_BADPOS;
            end else begin
               do_ins = 1'b1;
            end
         end
         plst_pkg::CMD_DEL_FRONT: begin
            if (empty) status = plst_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         plst_pkg::CMD_DEL_BACK: begin
            idx = plst_pkg::idx_type'(count_ff - 1'b1);
            if (empty) status = plst_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         plst_pkg::CMD_DEL_AT: begin
            idx = plst_pkg::idx_type'(position);
            if (empty) begin
               status = plst_pkg::ST_EMPTY;
            end else if (plst_pkg::cmp_type'(position) >= plst_pkg::cmp_type'(count_ff)) begin
               status = plst_pkg::ST_BADPOS;
            end else begin
               do_del = 1'b1;
            end
         end
         plst_pkg::CMD_SEARCH: begin
            if (match == '0) status = plst_pkg::ST_NOTFOUND;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) count_in = count_ff + 1'b1;
      else if (do_del) count_in = count_ff - 1'b1;

      rsp_in.status         = status;
      rsp_in.removed_value  = do_del ? pick_data : '0;
      rsp_in.found_position = '0;
      if (plst_pkg::cmd_type'(command) == plst_pkg::CMD_SEARCH && status == plst_pkg::ST_OK) begin
         rsp_in.found_position = plst_pkg::pos_type'(first_pos);
      end
      rsp_in.length = plst_pkg::pos_type'(count_in);
   end

   assign ctl.ins   = accept && do_ins;
   assign ctl.del   = accept && do_del;
   assign ctl.idx   = idx;
   assign ctl.value = value;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign count     = count_ff;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
